// File: rtl/device_mgmt_uri_checker_unit_macros.svh
// Assertion macros shared by the URI checker RTL.
// DUC_ASSERT is disabled while reset is asserted; DUC_ASSERT_ALWAYS is checked at every rising clock edge.
`ifndef DEVICE_MGMT_URI_CHECKER_UNIT_MACROS_SVH
`define DEVICE_MGMT_URI_CHECKER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define DUC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define DUC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DUC_ASSERT(label, prop, msg)
`define DUC_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// File: rtl/duc_pkg.sv
`timescale 1ns / 1ps

package duc_pkg;

	localparam int LEN_W = 16;
	localparam int CHAR_W = 8;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int STATUS_W = 3;
	localparam int M_TDATA_W = 40;
	localparam int M_PAD_W = M_TDATA_W - (STATUS_W + 1 + LEN_W + LEN_W + 1);

	typedef logic [LEN_W-1:0] len_t;
	typedef logic [CHAR_W-1:0] char_t;

	localparam len_t LEN_MAX = '1;

	localparam char_t CH_SLASH = 8'h2F;
	localparam char_t CH_DOT = 8'h2E;
	localparam char_t CH_PCT = 8'h25;
	localparam char_t CH_QMARK = 8'h3F;

	// index of the final token character ('=')
	localparam logic [2:0] TOK_LAST = 3'd5;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_TOTAL_LEN = 2'd0,
		REG_DEPTH = 2'd1,
		REG_SEG_LEN = 2'd2,
		REG_ALLOW_PROP = 2'd3
	} duc_reg_e;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK = 3'd0,
		ST_FAILED = 3'd1,
		ST_TOO_LONG = 3'd2,
		ST_LIST = 3'd3,
		ST_NOT_ALLOWED = 3'd4
	} duc_status_e;

	typedef enum logic [1:0] {
		ERR_NONE = 2'd0,
		ERR_FAILED = 2'd1,
		ERR_TOO_LONG = 2'd2
	} duc_err_e;

	typedef enum logic [1:0] {
		PH_START = 2'd0,
		PH_LEAD_DOT = 2'd1,
		PH_PATH = 2'd2,
		PH_STOP = 2'd3
	} duc_phase_e;

	typedef struct packed {
		len_t tot_lim;
		len_t depth_lim;
		len_t seg_lim;
		logic allow_prop;
	} duc_cfg_t;

	typedef struct packed {
		len_t pos;
		len_t seg_len;
		len_t segs;
		duc_phase_e phase;
		logic [1:0] esc;
		logic pdot;
		duc_err_e err_code;
		len_t err_pos;
		logic [2:0] pm;
		logic [2:0] lm;
		logic list_seen;
		logic prop_seen;
		len_t prop_start;
		len_t slash_end;
		logic first_dot;
	} duc_state_t;

	typedef struct packed {
		duc_status_e status;
		logic has_property;
		len_t property_offset;
		len_t node_length;
		logic prefix_added;
	} duc_result_t;

	localparam duc_state_t STATE_CLEAR = '{
		pos: '0, seg_len: '0, segs: '0, phase: PH_START, esc: '0, pdot: 1'b0,
		err_code: ERR_NONE, err_pos: '0, pm: '0, lm: '0, list_seen: 1'b0,
		prop_seen: 1'b0, prop_start: '0, slash_end: '0, first_dot: 1'b0
	};

	function automatic len_t sat_add(len_t v, len_t d);
		logic [LEN_W:0] s;
		s = {1'b0, v} + {1'b0, d};
		return s[LEN_W] ? LEN_MAX : s[LEN_W-1:0];
	endfunction

	function automatic len_t back(len_t v, len_t d);
		return (v >= d) ? (v - d) : '0;
	endfunction

	function automatic logic hex_ok(char_t c);
		return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
	endfunction

	function automatic logic seg_char_ok(char_t c);
		// letters, digits and : @ & = + $ , - _ ! ~ * ' ( )
		return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
			8'h3A, 8'h40, 8'h26, 8'h3D, 8'h2B, 8'h24, 8'h2C,
			8'h2D, 8'h5F, 8'h21, 8'h7E, 8'h2A, 8'h27, 8'h28, 8'h29};
	endfunction

	function automatic char_t tok_char(logic is_list, logic [2:0] idx);
		char_t ch;
		case (idx)
			3'd0: ch = CH_QMARK;
			3'd1: ch = is_list ? 8'h6C : 8'h70; // l / p
			3'd2: ch = is_list ? 8'h69 : 8'h72; // i / r
			3'd3: ch = is_list ? 8'h73 : 8'h6F; // s / o
			3'd4: ch = is_list ? 8'h74 : 8'h70; // t / p
			3'd5: ch = 8'h3D;                   // =
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic too_long(len_t len, len_t lim);
		return (lim != '0) && (len > lim);
	endfunction

	// first error wins; any error stops the path walk
	function automatic duc_state_t fail(duc_state_t s, duc_err_e code, len_t at);
		duc_state_t r;
		r = s;
		if (r.err_code == ERR_NONE) begin
			r.err_code = code;
			r.err_pos = at;
		end
		r.phase = PH_STOP;
		return r;
	endfunction

	function automatic duc_state_t path_char(duc_state_t s, char_t c, len_t pos,
			len_t seg_lim, len_t depth_lim);
		duc_state_t r;
		len_t pct;
		r = s;
		pct = back(pos, len_t'(2'd3 - s.esc));
		if (s.esc != 2'd0) begin
			if (!hex_ok(c)) begin
				r = fail(r, ERR_FAILED, pct);
			end else begin
				r.esc = s.esc - 2'd1;
				if (r.esc == 2'd0) begin
					r.seg_len = sat_add(s.seg_len, len_t'(3));
					if (too_long(r.seg_len, seg_lim)) begin
						r = fail(r, ERR_TOO_LONG, pct);
					end
				end
			end
		end else if (s.pdot && (c == CH_SLASH)) begin
			r.pdot = 1'b0;
			r = fail(r, ERR_FAILED, back(pos, len_t'(1)));
		end else if (s.pdot && too_long(s.seg_len, seg_lim)) begin
			r.pdot = 1'b0;
			r = fail(r, ERR_TOO_LONG, back(pos, len_t'(1)));
		end else begin
			r.pdot = 1'b0;
			case (c)
				CH_SLASH: begin
					if (s.seg_len == '0) begin
						r = fail(r, ERR_FAILED, pos);
					end else begin
						r.segs = sat_add(s.segs, len_t'(1));
						if ((depth_lim != '0) && (r.segs >= depth_lim)) begin
							r = fail(r, ERR_TOO_LONG, pos);
						end else begin
							r.seg_len = '0;
						end
					end
				end
				CH_DOT: begin
					r.seg_len = sat_add(s.seg_len, len_t'(1));
					r.pdot = 1'b1;
				end
				CH_PCT: begin
					r.esc = 2'd2;
				end
				default: begin
					if (!seg_char_ok(c)) begin
						r = fail(r, ERR_FAILED, pos);
					end else begin
						r.seg_len = sat_add(s.seg_len, len_t'(1));
						if (too_long(r.seg_len, seg_lim)) begin
							r = fail(r, ERR_TOO_LONG, pos);
						end
					end
				end
			endcase
		end
		return r;
	endfunction

	function automatic duc_state_t path_end(duc_state_t s, len_t len, len_t seg_lim);
		duc_state_t r;
		r = s;
		if (s.esc != 2'd0) begin
			r = fail(r, ERR_FAILED, back(len, len_t'(2'd3 - s.esc)));
		end else if (s.pdot && too_long(s.seg_len, seg_lim)) begin
			r = fail(r, ERR_TOO_LONG, back(len, len_t'(1)));
		end else if (s.seg_len == '0) begin
			r = fail(r, ERR_FAILED, len);
		end
		return r;
	endfunction

endpackage

// File: rtl/duc_parser.sv
`timescale 1ns / 1ps
`include "device_mgmt_uri_checker_unit_macros.svh"

module duc_parser (
	input logic clk,
	input logic arst_n,
	input logic step,
	input duc_pkg::char_t char_code,
	input logic is_last,
	input duc_pkg::duc_cfg_t cfg,
	output duc_pkg::duc_result_t result
);
	import duc_pkg::*;

	duc_state_t cur_q;
	duc_state_t w;
	duc_state_t e;
	duc_state_t state_d;
	logic do_path;
	len_t pos_inc;
	len_t node_len;
	duc_err_e err;

	// per-character walk: path checks, then token matching
	always_comb begin : walk_comb
		w = cur_q;
		do_path = 1'b0;
		pos_inc = sat_add(cur_q.pos, len_t'(1));
		w.pos = pos_inc;
		if (!cur_q.prop_seen) begin
			if (char_code == CH_SLASH) begin
				w.slash_end = pos_inc;
			end
			case (cur_q.phase)
				PH_START: begin
					if (char_code == CH_DOT) begin
						w.first_dot = 1'b1;
						w.phase = PH_LEAD_DOT;
					end else begin
						w.phase = PH_PATH;
						do_path = 1'b1;
					end
				end
				PH_LEAD_DOT: begin
					w.phase = PH_PATH;
					// "./" is skipped; any other char keeps the dot as segment text
					if (char_code != CH_SLASH) begin
						w.seg_len = len_t'(1);
						w.pdot = 1'b1;
						do_path = 1'b1;
					end
				end
				PH_PATH: begin
					do_path = 1'b1;
				end
				default: begin
				end
			endcase
			if (do_path) begin
				w = path_char(w, char_code, cur_q.pos, cfg.seg_lim, cfg.depth_lim);
			end
			if (char_code == tok_char(1'b0, cur_q.pm)) begin
				if (cur_q.pm == TOK_LAST) begin
					w.prop_seen = 1'b1;
					w.pm = '0;
					w.prop_start = back(cur_q.pos, len_t'(5));
					// node ends at the token, so later path errors don't count
					if ((w.err_code != ERR_NONE) && (w.err_pos >= w.prop_start)) begin
						w.err_code = ERR_NONE;
					end
					w.phase = PH_STOP;
				end else begin
					w.pm = cur_q.pm + 3'd1;
				end
			end else begin
				w.pm = (char_code == CH_QMARK) ? 3'd1 : 3'd0;
			end
		end
		if (!cur_q.list_seen) begin
			if (char_code == tok_char(1'b1, cur_q.lm)) begin
				if (cur_q.lm == TOK_LAST) begin
					w.list_seen = 1'b1;
					w.lm = '0;
				end else begin
					w.lm = cur_q.lm + 3'd1;
				end
			end else begin
				w.lm = (char_code == CH_QMARK) ? 3'd1 : 3'd0;
			end
		end
	end

	// end-of-URI checks and status priority
	always_comb begin : result_comb
		e = w;
		node_len = w.prop_seen ? w.prop_start : w.pos;
		if (!w.prop_seen && (w.phase == PH_PATH)) begin
			e = path_end(w, w.pos, cfg.seg_lim);
		end
		err = e.err_code;
		// a node of exactly "." is not checked
		if ((node_len == len_t'(1)) && w.first_dot) begin
			err = ERR_NONE;
		end
		if ((cfg.tot_lim != '0) && (w.pos > cfg.tot_lim)) begin
			result.status = ST_TOO_LONG;
		end else if (w.list_seen) begin
			result.status = ST_LIST;
		end else if (w.prop_seen && !cfg.allow_prop) begin
			result.status = ST_NOT_ALLOWED;
		end else if (node_len == '0) begin
			result.status = ST_FAILED;
		end else if (w.slash_end == node_len) begin
			result.status = ST_FAILED;
		end else begin
			case (err)
				ERR_FAILED: result.status = ST_FAILED;
				ERR_TOO_LONG: result.status = ST_TOO_LONG;
				default: result.status = ST_OK;
			endcase
		end
		result.has_property = w.prop_seen;
		result.property_offset = w.prop_seen ? sat_add(w.prop_start, len_t'(6)) : '0;
		result.node_length = node_len;
		result.prefix_added = (node_len != '0) && !w.first_dot;
	end

	always_comb begin : next_comb
		state_d = is_last ? STATE_CLEAR : w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= STATE_CLEAR;
		end else if (step) begin
			cur_q <= state_d;
		end
	end

	`DUC_ASSERT(a_clear_after_last, step && is_last |=> (cur_q.pos == '0) && !cur_q.prop_seen && !cur_q.list_seen, "URI state not cleared after last item")
	`DUC_ASSERT(a_prop_before_pos, cur_q.prop_seen |-> (cur_q.prop_start < cur_q.pos), "property start not behind position")
	`DUC_ASSERT(a_hold_without_step, !step |=> $stable(cur_q), "URI state changed without an item")

endmodule

// File: rtl/device_mgmt_uri_checker_unit.sv
`timescale 1ns / 1ps
`include "device_mgmt_uri_checker_unit_macros.svh"
// Channel   Dir  Payload
// s_*       in   tdata = char_code, tlast = is_last
// m_*       out  tdata = status, has_property, property_offset, node_length, prefix_added
// cfg_*     in   register write: index, value
//
// One character per cycle, sustained while no result waits on m_tready. Each character
// passes one input register, then the parse logic feeding the result register.
// Only the last character of a URI produces a result item.
// Reset clears the parse state, the stage valids and the config registers to their defaults.
// While a result waits on m_tready, the input register still accepts one more item;
// further items stall until the result is taken.

module device_mgmt_uri_checker_unit (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [duc_pkg::CHAR_W-1:0] s_tdata, // [7:0] char_code
	input logic s_tlast,
	output logic m_tvalid,
	input logic m_tready,
	// [2:0] status, [3] has_property, [19:4] property_offset,
	// [35:20] node_length, [36] prefix_added, [39:37] zero
	output logic [duc_pkg::M_TDATA_W-1:0] m_tdata,
	input logic cfg_we,
	input logic [duc_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input logic [duc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import duc_pkg::*;

	duc_cfg_t cfg_q;
	logic valid_s1;
	char_t char_s1;
	logic last_s1;
	logic step;
	logic out_valid_q;
	logic [M_TDATA_W-1:0] out_data_q;
	duc_result_t result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tot_lim <= '0;
			cfg_q.depth_lim <= '0;
			cfg_q.seg_lim <= '0;
			cfg_q.allow_prop <= 1'b1;
		end else if (cfg_we) begin
			case (duc_reg_e'(cfg_addr))
				REG_TOTAL_LEN: cfg_q.tot_lim <= len_t'(cfg_wdata);
				REG_DEPTH: cfg_q.depth_lim <= len_t'(cfg_wdata);
				REG_SEG_LEN: cfg_q.seg_lim <= len_t'(cfg_wdata);
				REG_ALLOW_PROP: cfg_q.allow_prop <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	assign step = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	duc_parser u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.char_code(char_s1),
		.is_last(last_s1),
		.cfg(cfg_q),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			out_data_q <= {M_PAD_W'(0), result.prefix_added, result.node_length,
				result.property_offset, result.has_property, result.status};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

	`DUC_ASSERT(a_no_overwrite, out_valid_q && !m_tready |-> !step, "pending result would be overwritten")
	`DUC_ASSERT(a_result_from_last, $rose(out_valid_q) |-> $past(valid_s1 && last_s1), "result without a last item")
	`DUC_ASSERT(a_s1_held, valid_s1 && !step |=> valid_s1, "stalled input item dropped")

endmodule

// File: sim/tb_device_mgmt_uri_checker_unit.sv
`timescale 1ns / 1ps

module tb_device_mgmt_uri_checker_unit;
	import duc_pkg::*;

	localparam int LEN_TOP = (1 << LEN_W) - 1;
	localparam int IDLE_LIMIT = 3000;
	localparam string PROP_WORD = "?prop=";
	localparam string LIST_WORD = "?list=";
	localparam string SEG_POOL = "abcdqXYZ0579:@&=+$,-_!~*'()";
	localparam string HEX_POOL = "0123456789abcdefABCDEF";
	localparam string NOISE_POOL = "?prolist=./%aB";

	typedef struct {
		char_t ch;
		logic last;
		logic drain_first;
	} uri_char_t;

	typedef struct {
		duc_status_e status;
		logic has_prop;
		len_t prop_offset;
		len_t node_len;
		logic prefix;
	} uri_verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [CHAR_W-1:0] s_tdata = '0; // [7:0] char_code
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// [2:0] status, [3] has_property, [19:4] property_offset,
	// [35:20] node_length, [36] prefix_added, [39:37] zero
	logic [M_TDATA_W-1:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	device_mgmt_uri_checker_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always #6 clk = ~clk;

	uri_char_t pend_q[$];
	uri_verdict_t verdict_q[$];
	char_t uri_buf[$];
	int mismatch_count = 0;
	int idle_cycles = 0;
	logic char_taken = 1'b0;
	int burst_left = 0;
	int gap_left = 0;
	int stall_tick = 0;
	int stall_mode = 0;

	// register copies
	int max_total = 0;
	int depth_cap = 0;
	int max_seg = 0;
	logic prop_allowed = 1'b1;

	// per-URI parse state
	int at_pos = 0;
	int seg_run = 0;
	int seg_count = 0;
	duc_phase_e walk_phase = PH_START;
	int hex_left = 0;
	logic dot_pending = 1'b0;
	duc_err_e path_err = ERR_NONE;
	int path_err_at = 0;
	int prop_hits = 0;
	int list_hits = 0;
	logic list_found = 1'b0;
	logic prop_found = 1'b0;
	int prop_at = 0;
	int last_slash_end = 0;
	logic lead_dot = 1'b0;

	function automatic int sat_len(int v);
		return (v > LEN_TOP) ? LEN_TOP : v;
	endfunction

	function automatic int step_back(int v, int d);
		return (v >= d) ? v - d : 0;
	endfunction

	function automatic logic is_hex(char_t c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
	endfunction

	function automatic logic is_seg_char(char_t c);
		if ((c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z"))
			return 1'b1;
		case (c)
			":", "@", "&", "=", "+", "$", ",", "-", "_", "!", "~", "*", "'", "(", ")":
				return 1'b1;
			default:
				return 1'b0;
		endcase
	endfunction

	function automatic logic seg_over();
		return (max_seg != 0) && (seg_run > max_seg);
	endfunction

	task automatic clear_uri_state();
		at_pos = 0;
		seg_run = 0;
		seg_count = 0;
		walk_phase = PH_START;
		hex_left = 0;
		dot_pending = 1'b0;
		path_err = ERR_NONE;
		path_err_at = 0;
		prop_hits = 0;
		list_hits = 0;
		list_found = 1'b0;
		prop_found = 1'b0;
		prop_at = 0;
		last_slash_end = 0;
		lead_dot = 1'b0;
	endtask

	// only the first path error is kept; any error ends the walk
	task automatic flag_path(duc_err_e code, int at);
		if (path_err == ERR_NONE) begin
			path_err = code;
			path_err_at = at;
		end
		walk_phase = PH_STOP;
	endtask

	task automatic walk_char(char_t c, int pos);
		int pct;
		if (hex_left != 0) begin
			pct = step_back(pos, 3 - hex_left);
			if (!is_hex(c)) begin
				flag_path(ERR_FAILED, pct);
				return;
			end
			hex_left--;
			if (hex_left == 0) begin
				seg_run = sat_len(seg_run + 3);
				if (seg_over())
					flag_path(ERR_TOO_LONG, pct);
			end
			return;
		end
		if (dot_pending) begin
			dot_pending = 1'b0;
			if (c == CH_SLASH) begin
				flag_path(ERR_FAILED, step_back(pos, 1));
				return;
			end
			if (seg_over()) begin
				flag_path(ERR_TOO_LONG, step_back(pos, 1));
				return;
			end
		end
		if (c == CH_SLASH) begin
			if (seg_run == 0) begin
				flag_path(ERR_FAILED, pos);
				return;
			end
			seg_count = sat_len(seg_count + 1);
			if (depth_cap != 0 && seg_count >= depth_cap) begin
				flag_path(ERR_TOO_LONG, pos);
				return;
			end
			seg_run = 0;
		end else if (c == CH_DOT) begin
			seg_run = sat_len(seg_run + 1);
			dot_pending = 1'b1;
		end else if (c == CH_PCT) begin
			hex_left = 2;
		end else if (!is_seg_char(c)) begin
			flag_path(ERR_FAILED, pos);
		end else begin
			seg_run = sat_len(seg_run + 1);
			if (seg_over())
				flag_path(ERR_TOO_LONG, pos);
		end
	endtask

	task automatic close_path(int len);
		if (hex_left != 0)
			flag_path(ERR_FAILED, step_back(len, 3 - hex_left));
		else if (dot_pending && seg_over())
			flag_path(ERR_TOO_LONG, step_back(len, 1));
		else if (seg_run == 0)
			flag_path(ERR_FAILED, len);
	endtask

	// advances the URI parse by one character; a final character queues the verdict
	task automatic scan_char(char_t c, logic last);
		int pos;
		int node_len;
		uri_verdict_t v;
		pos = at_pos;
		at_pos = sat_len(pos + 1);
		if (!prop_found) begin
			if (c == CH_SLASH)
				last_slash_end = at_pos;
			case (walk_phase)
				PH_START: begin
					if (c == CH_DOT) begin
						lead_dot = 1'b1;
						walk_phase = PH_LEAD_DOT;
					end else begin
						walk_phase = PH_PATH;
						walk_char(c, pos);
					end
				end
				PH_LEAD_DOT: begin
					walk_phase = PH_PATH;
					if (c != CH_SLASH) begin
						seg_run = 1;
						dot_pending = 1'b1;
						walk_char(c, pos);
					end
				end
				PH_PATH: walk_char(c, pos);
				default: ;
			endcase
			if (c == char_t'(PROP_WORD[prop_hits])) begin
				prop_hits++;
				if (prop_hits == 6) begin
					prop_found = 1'b1;
					prop_hits = 0;
					prop_at = step_back(pos, 5);
					// node ends at the token, so later errors do not count
					if (path_err != ERR_NONE && path_err_at >= prop_at)
						path_err = ERR_NONE;
					walk_phase = PH_STOP;
				end
			end else begin
				prop_hits = (c == CH_QMARK) ? 1 : 0;
			end
		end
		if (!list_found) begin
			if (c == char_t'(LIST_WORD[list_hits])) begin
				list_hits++;
				if (list_hits == 6) begin
					list_found = 1'b1;
					list_hits = 0;
				end
			end else begin
				list_hits = (c == CH_QMARK) ? 1 : 0;
			end
		end
		if (!last)
			return;
		node_len = prop_found ? prop_at : at_pos;
		if (!prop_found && walk_phase == PH_PATH)
			close_path(at_pos);
		if (node_len == 1 && lead_dot)
			path_err = ERR_NONE;
		if (max_total != 0 && at_pos > max_total)
			v.status = ST_TOO_LONG;
		else if (list_found)
			v.status = ST_LIST;
		else if (prop_found && !prop_allowed)
			v.status = ST_NOT_ALLOWED;
		else if (node_len == 0 || last_slash_end == node_len)
			v.status = ST_FAILED;
		else if (path_err == ERR_FAILED)
			v.status = ST_FAILED;
		else if (path_err == ERR_TOO_LONG)
			v.status = ST_TOO_LONG;
		else
			v.status = ST_OK;
		v.has_prop = prop_found;
		v.prop_offset = prop_found ? len_t'(sat_len(prop_at + 6)) : '0;
		v.node_len = len_t'(node_len);
		v.prefix = (node_len != 0) && !lead_dot;
		verdict_q.push_back(v);
		clear_uri_state();
	endtask

	task automatic check_verdict(logic [M_TDATA_W-1:0] d);
		uri_verdict_t v;
		if (verdict_q.size() == 0) begin
			$error("result item with no URI pending: tdata %h", d);
			mismatch_count++;
			return;
		end
		v = verdict_q.pop_front();
		if (d[2:0] !== v.status) begin
			$error("status: expected %0d, actual %0d", v.status, d[2:0]);
			mismatch_count++;
		end
		if (d[3] !== v.has_prop) begin
			$error("has_property: expected %0d, actual %0d", v.has_prop, d[3]);
			mismatch_count++;
		end
		if (d[19:4] !== v.prop_offset) begin
			$error("property_offset: expected %0d, actual %0d", v.prop_offset, d[19:4]);
			mismatch_count++;
		end
		if (d[35:20] !== v.node_len) begin
			$error("node_length: expected %0d, actual %0d", v.node_len, d[35:20]);
			mismatch_count++;
		end
		if (d[36] !== v.prefix) begin
			$error("prefix_added: expected %0d, actual %0d", v.prefix, d[36]);
			mismatch_count++;
		end
	endtask

	// monitor: register copies, result check, prediction
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				case (duc_reg_e'(cfg_addr))
					REG_TOTAL_LEN: max_total = int'(cfg_wdata);
					REG_DEPTH: depth_cap = int'(cfg_wdata);
					REG_SEG_LEN: max_seg = int'(cfg_wdata);
					REG_ALLOW_PROP: prop_allowed = cfg_wdata[0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready)
				check_verdict(m_tdata);
			if (s_tvalid && s_tready)
				scan_char(s_tdata, s_tlast);
		end
		char_taken <= arst_n && s_tvalid && s_tready;
	end

	// sender: bursts with random gaps
	always @(negedge clk) begin : drive_chars
		uri_char_t nxt;
		logic go;
		int r;
		if (arst_n && (!s_tvalid || char_taken)) begin
			go = 1'b0;
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
			end else if (pend_q.size() != 0 &&
					!(pend_q[0].drain_first && verdict_q.size() != 0)) begin
				nxt = pend_q.pop_front();
				go = 1'b1;
				s_tdata <= nxt.ch;
				s_tlast <= nxt.last;
				if (burst_left <= 1) begin
					burst_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
						: $urandom_range(1, 24);
					r = $urandom_range(0, 99);
					if (r < 45)
						gap_left <= 0;
					else if (r < 80)
						gap_left <= $urandom_range(1, 3);
					else if (r < 95)
						gap_left <= $urandom_range(4, 10);
					else
						gap_left <= $urandom_range(11, 30);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
			s_tvalid <= go;
		end
	end

	// receiver: m_tready follows a randomly chosen stall mode
	always @(negedge clk) begin
		stall_tick <= stall_tick + 1;
		if (stall_tick % 64 == 0)
			stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			2: m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= (stall_tick % 8) < 3;
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	task automatic send_uri(logic drain_first);
		uri_char_t it;
		if (uri_buf.size() == 0)
			uri_buf.push_back("a");
		for (int i = 0; i < uri_buf.size(); i++) begin
			it.ch = uri_buf[i];
			it.last = (i == uri_buf.size() - 1);
			it.drain_first = drain_first && (i == 0);
			pend_q.push_back(it);
		end
		uri_buf.delete();
	endtask

	task automatic put_str(string s);
		for (int i = 0; i < s.len(); i++)
			uri_buf.push_back(char_t'(s[i]));
	endtask

	task automatic send_str(string s);
		put_str(s);
		send_uri(1'b0);
	endtask

	function automatic char_t pick(string s);
		return char_t'(s[$urandom_range(0, s.len() - 1)]);
	endfunction

	task automatic put_segment();
		int n;
		int r;
		n = $urandom_range(1, 5);
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				uri_buf.push_back(CH_PCT);
				uri_buf.push_back(pick(HEX_POOL));
				uri_buf.push_back(pick(HEX_POOL));
			end else if (r < 11) begin
				// escape with one bad digit
				uri_buf.push_back(CH_PCT);
				if ($urandom_range(0, 1)) begin
					uri_buf.push_back(pick("gGz/."));
					uri_buf.push_back(pick(HEX_POOL));
				end else begin
					uri_buf.push_back(pick(HEX_POOL));
					uri_buf.push_back(pick("gGz/."));
				end
			end else if (r < 19) begin
				uri_buf.push_back(CH_DOT);
			end else if (r < 22) begin
				uri_buf.push_back(char_t'($urandom_range(1, 255)));
			end else begin
				uri_buf.push_back(pick(SEG_POOL));
			end
		end
	endtask

	task automatic make_uri();
		int r;
		int nseg;
		if ($urandom_range(0, 99) < 80) begin
			r = $urandom_range(0, 99);
			if (r >= 60 && r < 85)
				put_str("./");
			else if (r >= 85 && r < 95)
				uri_buf.push_back(CH_DOT);
			nseg = $urandom_range(1, 4);
			for (int i = 0; i < nseg; i++) begin
				if (i != 0) begin
					uri_buf.push_back(CH_SLASH);
					if ($urandom_range(0, 19) == 0)
						uri_buf.push_back(CH_SLASH);
				end
				put_segment();
			end
			r = $urandom_range(0, 99);
			if (r < 5)
				uri_buf.push_back(CH_SLASH);
			else if (r < 8)
				uri_buf.push_back(CH_DOT);
			else if (r < 11)
				uri_buf.push_back(CH_PCT);
			else if (r < 13)
				put_str("%a");
			r = $urandom_range(0, 99);
			if (r < 28) begin
				put_str(PROP_WORD);
				for (int i = $urandom_range(0, 3); i > 0; i--)
					uri_buf.push_back(pick(SEG_POOL));
			end else if (r < 34) begin
				put_str(LIST_WORD);
				if ($urandom_range(0, 1))
					put_str("?prop=x");
			end else if (r < 38) begin
				put_str($urandom_range(0, 1) ? "?pro" : "??li");
			end
		end else begin
			for (int i = $urandom_range(1, 8); i > 0; i--)
				uri_buf.push_back($urandom_range(0, 1) ? pick(NOISE_POOL)
					: char_t'($urandom_range(1, 255)));
		end
	endtask

	task automatic queue_random(int chars);
		int start;
		start = pend_q.size();
		while (pend_q.size() - start < chars) begin
			make_uri();
			send_uri($urandom_range(0, 19) == 0);
		end
	endtask

	task automatic write_reg(duc_reg_e idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
	endtask

	task automatic set_limits(int total, int depth, int seg, logic allow);
		write_reg(REG_TOTAL_LEN, CFG_DATA_W'(total));
		write_reg(REG_DEPTH, CFG_DATA_W'(depth));
		write_reg(REG_SEG_LEN, CFG_DATA_W'(seg));
		// upper bits are don't-care for the flag
		write_reg(REG_ALLOW_PROP, {(CFG_DATA_W-1)'($urandom), allow});
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic settle();
		while (pend_q.size() != 0 || s_tvalid || verdict_q.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset defaults: node and token corner cases
		send_str(".");
		send_str("./");
		send_str("a/");
		send_str("a%4");
		send_str("a.");
		send_str("%4g");
		send_str("?list=");
		send_str("b?prop=");
		uri_buf.push_back(8'h00);
		uri_buf.push_back(8'hFF);
		send_uri(1'b0);
		send_str("~*'()");
		queue_random(60);
		settle();

		set_limits(8, 2, 3, 1'b0);
		queue_random(60);
		settle();

		// widest limits with one long plain segment
		set_limits(LEN_TOP, LEN_TOP, LEN_TOP, 1'b1);
		for (int i = 0; i < 30; i++)
			uri_buf.push_back("a");
		send_uri(1'b0);
		queue_random(60);
		settle();

		set_limits(1, 1, 1, 1'b1);
		queue_random(60);
		settle();

		set_limits(0, 0, 0, 1'b0);
		queue_random(60);
		settle();

		repeat (3) begin
			set_limits($urandom_range(10, 40), $urandom_range(1, 4), $urandom_range(2, 8),
				1'($urandom_range(0, 1)));
			queue_random(30);
			settle();
		end

		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl
rtl/duc_pkg.sv
rtl/duc_parser.sv
rtl/device_mgmt_uri_checker_unit.sv
sim/tb_device_mgmt_uri_checker_unit.sv
